[src/signed_byte_alu_mul_div_defines.svh]
// ----------------------------------------------------------------------------
// signed_byte_alu_mul_div assertion macros
// concurrent assertion helpers clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SIGNED_BYTE_ALU_MUL_DIV_DEFINES_SVH
`define SIGNED_BYTE_ALU_MUL_DIV_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SBAMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define SBAMD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/sbamd_pkg.sv]
// ----------------------------------------------------------------------------
// sbamd_pkg
// operation codes and per-request control word for the signed alu pipeline
// ----------------------------------------------------------------------------
package sbamd_pkg;

  localparam int MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_REM = 3'd4
  } mode_t;

  // control that travels with each request down the pipe
  typedef struct packed {
    mode_t mode;
    logic  sign_a;
    logic  sign_b;
    logic  div_zero;
  } ctl_t;

endpackage

[src/sbamd_pre.sv]
// ----------------------------------------------------------------------------
// sbamd_pre
// entry stage: decode, add/sub/mul, operand magnitudes for the divider
// ----------------------------------------------------------------------------
module sbamd_pre #(
  parameter int WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [sbamd_pkg::MODE_W-1:0] mode_i,
  input  logic [WIDTH-1:0]             a_i,
  input  logic [WIDTH-1:0]             b_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output sbamd_pkg::ctl_t              ctl_o,
  output logic [WIDTH:0]               acc_o,
  output logic [WIDTH-1:0]             q_o,
  output logic [WIDTH-1:0]             div_o
);

  logic                 valid_r;
  sbamd_pkg::ctl_t      ctl_r, ctl_nxt;
  logic [WIDTH:0]       acc_r;
  logic [WIDTH-1:0]     q_r, q_nxt;
  logic [WIDTH-1:0]     div_r, div_nxt;
  logic [2*WIDTH-1:0]   prod;
  logic [WIDTH-1:0]     mag_a;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    ctl_nxt.mode     = sbamd_pkg::mode_t'(mode_i);
    ctl_nxt.sign_a   = a_i[WIDTH-1];
    ctl_nxt.sign_b   = b_i[WIDTH-1];
    ctl_nxt.div_zero = ((ctl_nxt.mode == sbamd_pkg::MODE_DIV) ||
                        (ctl_nxt.mode == sbamd_pkg::MODE_REM)) && (b_i == '0);
    prod    = {{WIDTH{1'b0}}, a_i} * {{WIDTH{1'b0}}, b_i};
    mag_a   = a_i[WIDTH-1] ? (~a_i + 1'b1) : a_i;
    div_nxt = b_i[WIDTH-1] ? (~b_i + 1'b1) : b_i;
    unique case (ctl_nxt.mode)
      sbamd_pkg::MODE_ADD: q_nxt = a_i + b_i;
      sbamd_pkg::MODE_SUB: q_nxt = a_i + (~b_i + 1'b1);
      sbamd_pkg::MODE_MUL: q_nxt = prod[WIDTH-1:0];
      sbamd_pkg::MODE_DIV,
      sbamd_pkg::MODE_REM: q_nxt = mag_a;
      default:             q_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      ctl_r <= ctl_nxt;
      acc_r <= '0;
      q_r   <= q_nxt;
      div_r <= div_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign acc_o   = acc_r;
  assign q_o     = q_r;
  assign div_o   = div_r;

endmodule

[src/sbamd_div_step.sv]
// ----------------------------------------------------------------------------
// sbamd_div_step
// one registered restoring-division step, pass-through for other modes
// ----------------------------------------------------------------------------
module sbamd_div_step #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  output logic             ready_o,
  input  sbamd_pkg::ctl_t  ctl_i,
  input  logic [WIDTH:0]   acc_i,
  input  logic [WIDTH-1:0] q_i,
  input  logic [WIDTH-1:0] div_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sbamd_pkg::ctl_t  ctl_o,
  output logic [WIDTH:0]   acc_o,
  output logic [WIDTH-1:0] q_o,
  output logic [WIDTH-1:0] div_o
);

  logic             valid_r;
  sbamd_pkg::ctl_t  ctl_r;
  logic [WIDTH:0]   acc_r, acc_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] div_r;
  logic [WIDTH:0]   acc_sh;
  logic [WIDTH-1:0] q_sh;
  logic             is_div;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    is_div = (ctl_i.mode == sbamd_pkg::MODE_DIV) || (ctl_i.mode == sbamd_pkg::MODE_REM);
    acc_sh = {acc_i[WIDTH-1:0], q_i[WIDTH-1]};
    q_sh   = {q_i[WIDTH-2:0], 1'b0};
    if (!is_div) begin
      acc_nxt = acc_i;
      q_nxt   = q_i;
    end else if (acc_sh >= {1'b0, div_i}) begin
      acc_nxt = acc_sh - {1'b0, div_i};
      q_nxt   = q_sh | {{(WIDTH-1){1'b0}}, 1'b1};
    end else begin
      acc_nxt = acc_sh;
      q_nxt   = q_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      ctl_r <= ctl_i;
      acc_r <= acc_nxt;
      q_r   <= q_nxt;
      div_r <= div_i;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign acc_o   = acc_r;
  assign q_o     = q_r;
  assign div_o   = div_r;

endmodule

[src/sbamd_post.sv]
// ----------------------------------------------------------------------------
// sbamd_post
// output stage: sign fix of quotient and remainder, result select
// ----------------------------------------------------------------------------
module sbamd_post #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  output logic             ready_o,
  input  sbamd_pkg::ctl_t  ctl_i,
  input  logic [WIDTH:0]   acc_i,
  input  logic [WIDTH-1:0] q_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] result_o,
  output logic             div_zero_o
);

  logic             valid_r;
  logic [WIDTH-1:0] result_r, result_nxt;
  logic             dz_r;
  logic [WIDTH-1:0] rem;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    rem = acc_i[WIDTH-1:0];
    unique case (ctl_i.mode)
      sbamd_pkg::MODE_ADD,
      sbamd_pkg::MODE_SUB,
      sbamd_pkg::MODE_MUL: result_nxt = q_i;
      sbamd_pkg::MODE_DIV: result_nxt = (ctl_i.sign_a ^ ctl_i.sign_b) ? (~q_i + 1'b1) : q_i;
      sbamd_pkg::MODE_REM: result_nxt = ctl_i.sign_a ? (~rem + 1'b1) : rem;
      default:             result_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      result_r <= result_nxt;
      dz_r     <= ctl_i.div_zero;
    end
  end

  assign valid_o    = valid_r;
  assign result_o   = result_r;
  assign div_zero_o = dz_r;

endmodule

[src/signed_byte_alu_mul_div.sv]
// ----------------------------------------------------------------------------
// signed_byte_alu_mul_div
// pipelined signed add, subtract, multiply, divide and remainder
// ----------------------------------------------------------------------------
//
//  channel   ports                                          direction
//  request   in_valid in_ready in_mode in_operand_a/_b      into block
//  result    out_valid out_ready out_result out_div_by_zero out of block
//
//  one request accepted per cycle when the pipe flows
//  the pipe is an entry stage, WIDTH divider step stages and an output stage;
//  the divider step chain sets the depth
//  reset clears only the stage valid bits, data registers are left as they are
//  each stage holds its request while the next stage is full and stalled, so a
//  bubble anywhere still lets a new request in
// ----------------------------------------------------------------------------
`include "signed_byte_alu_mul_div_defines.svh"

module signed_byte_alu_mul_div #(
  parameter int WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sbamd_pkg::MODE_W-1:0] in_mode,
  input  logic signed [WIDTH-1:0]      in_operand_a,
  input  logic signed [WIDTH-1:0]      in_operand_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WIDTH-1:0]      out_result,
  output logic                         out_div_by_zero
);

  // stage links: index 0 leaves the entry stage, index WIDTH feeds the output
  logic             step_valid [0:WIDTH];
  logic             step_ready [0:WIDTH];
  sbamd_pkg::ctl_t  step_ctl   [0:WIDTH];
  logic [WIDTH:0]   step_acc   [0:WIDTH];
  logic [WIDTH-1:0] step_q     [0:WIDTH];
  logic [WIDTH-1:0] step_div   [0:WIDTH];
  logic [WIDTH-1:0] result_w;

  // entry: decode, add/sub/mul done here, magnitudes set up for division
  sbamd_pre #(.WIDTH(WIDTH)) u_pre (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .mode_i  (in_mode),
    .a_i     (in_operand_a),
    .b_i     (in_operand_b),
    .valid_o (step_valid[0]),
    .ready_i (step_ready[0]),
    .ctl_o   (step_ctl[0]),
    .acc_o   (step_acc[0]),
    .q_o     (step_q[0]),
    .div_o   (step_div[0])
  );

  // one restoring step per stage, quotient bits shift in from the bottom
  for (genvar g = 0; g < WIDTH; g++) begin : g_step
    sbamd_div_step #(.WIDTH(WIDTH)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (step_valid[g]),
      .ready_o (step_ready[g]),
      .ctl_i   (step_ctl[g]),
      .acc_i   (step_acc[g]),
      .q_i     (step_q[g]),
      .div_i   (step_div[g]),
      .valid_o (step_valid[g+1]),
      .ready_i (step_ready[g+1]),
      .ctl_o   (step_ctl[g+1]),
      .acc_o   (step_acc[g+1]),
      .q_o     (step_q[g+1]),
      .div_o   (step_div[g+1])
    );
  end

  // output register: signs applied, result chosen by mode
  sbamd_post #(.WIDTH(WIDTH)) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (step_valid[WIDTH]),
    .ready_o    (step_ready[WIDTH]),
    .ctl_i      (step_ctl[WIDTH]),
    .acc_i      (step_acc[WIDTH]),
    .q_i        (step_q[WIDTH]),
    .valid_o    (out_valid),
    .ready_i    (out_ready),
    .result_o   (result_w),
    .div_zero_o (out_div_by_zero)
  );

  assign out_result = result_w;

  // the entry only refuses a request when every stage is full behind a stall
  `SBAMD_ASSERT(a_full_stall, !in_ready |-> (out_valid && !out_ready), "entry stalled with room in pipe")
  // a result only appears after the last divider stage held a request
  `SBAMD_ASSERT(a_out_source, $rose(out_valid) |-> $past(step_valid[WIDTH]), "result from nowhere")
  // zero divisor drives every quotient bit to one
  `SBAMD_ASSERT(a_zero_quot, (step_valid[WIDTH] && step_ctl[WIDTH].div_zero) |-> (step_q[WIDTH] == '1), "zero divisor quotient not all ones")
  // the zero flag is only raised for divide and remainder
  `SBAMD_NEVER(a_dz_mode, step_valid[0] && step_ctl[0].div_zero && (step_ctl[0].mode != sbamd_pkg::MODE_DIV) && (step_ctl[0].mode != sbamd_pkg::MODE_REM), "zero flag on non-division")

endmodule

[tb/signed_byte_alu_mul_div_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_byte_alu_mul_div testbench
// add, subtract, multiply, divide, remainder and unused-mode requests with
// random gaps on both channels in two of the four tests, each result checked in order
// against a local arithmetic model
// ----------------------------------------------------------------------------
module signed_byte_alu_mul_div_tb;

  localparam int DATA_W      = 8;
  localparam int LATENCY     = DATA_W + 2;  // entry stage, divider steps, output stage
  localparam int IDLE_MAX    = 14;
  localparam int HOLD_CYCLES = 80;          // long receiver hold-off, fills the pipe
  localparam int STALL_LIMIT = 1000;        // cycles with no handshake before giving up

  // mode codes the package leaves undefined, the unit must answer them with zero
  localparam logic [sbamd_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [sbamd_pkg::MODE_W-1:0] MODE_CODE_LAST    = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     div_by_zero;
  } alu_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [sbamd_pkg::MODE_W-1:0] in_mode;
  logic signed [DATA_W-1:0]     in_operand_a;
  logic signed [DATA_W-1:0]     in_operand_b;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [DATA_W-1:0]     out_result;
  logic                         out_div_by_zero;

  // predicted results, oldest first
  alu_result_t pending_results[$];
  alu_result_t oldest;

  // idling controls shared between the stimulus and the receiver
  bit sender_gaps_on   = 1'b1;
  bit receiver_gaps_on = 1'b1;
  bit hold_pending     = 1'b0;

  int error_count         = 0;
  int request_count       = 0;
  int result_count        = 0;
  int dz_count            = 0;
  int backpressure_cycles = 0;
  int quiet_cycles        = 0;
  int mode_count[8];

  signed_byte_alu_mul_div #(
    .WIDTH(DATA_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_div_by_zero(out_div_by_zero)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // arithmetic model: wrapping add/sub, low byte of the product, and
  // restoring division on magnitudes with a 9-bit partial remainder
  function automatic alu_result_t predict_alu(input logic [sbamd_pkg::MODE_W-1:0] mode,
                                              input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    alu_result_t       r;
    logic [DATA_W:0]   part;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    int                i;
    r.result      = '0;
    r.div_by_zero = 1'b0;
    case (mode)
      sbamd_pkg::MODE_ADD: r.result = a + b;
      sbamd_pkg::MODE_SUB: r.result = a - b;
      sbamd_pkg::MODE_MUL: r.result = a * b;
      sbamd_pkg::MODE_DIV, sbamd_pkg::MODE_REM: begin
        mag_a = a[DATA_W-1] ? -a : a;
        mag_b = b[DATA_W-1] ? -b : b;
        part  = '0;
        quo   = mag_a;
        for (i = 0; i < DATA_W; i++) begin
          part = {part[DATA_W-1:0], quo[DATA_W-1]};
          quo  = quo << 1;
          if (part >= {1'b0, mag_b}) begin
            part   = part - {1'b0, mag_b};
            quo[0] = 1'b1;
          end
        end
        // a zero divisor leaves an all-ones quotient and the dividend as remainder
        r.div_by_zero = (b == '0);
        if (mode == sbamd_pkg::MODE_DIV)
          r.result = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quo : quo;
        else
          r.result = a[DATA_W-1] ? -part[DATA_W-1:0] : part[DATA_W-1:0];
      end
      default: r.result = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // offer one request, after a random gap when the sender is idling
  task automatic send_request(input logic [sbamd_pkg::MODE_W-1:0] mode,
                              input logic signed [DATA_W-1:0] a,
                              input logic signed [DATA_W-1:0] b);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // sender pauses until every outstanding result is back, then the pipe settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    v = DATA_W'($urandom);
    // bias towards the corners of the signed range
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0:       v = 8'h80;
        1:       v = 8'h7f;
        2:       v = 8'hff;
        3:       v = 8'h00;
        default: v = 8'h01;
      endcase
    end
    return v;
  endfunction

  function automatic logic [sbamd_pkg::MODE_W-1:0] pick_mode();
    int sel;
    logic [sbamd_pkg::MODE_W-1:0] m;
    sel = $urandom_range(0, 20);
    if (sel == 20)
      m = sbamd_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_CODE_LAST));
    else begin
      case (sel / 4)
        0:       m = sbamd_pkg::MODE_ADD;
        1:       m = sbamd_pkg::MODE_SUB;
        2:       m = sbamd_pkg::MODE_MUL;
        3:       m = sbamd_pkg::MODE_DIV;
        default: m = sbamd_pkg::MODE_REM;
      endcase
    end
    return m;
  endfunction

  task automatic send_random(input int count);
    logic [sbamd_pkg::MODE_W-1:0] mode;
    logic [DATA_W-1:0]            b;
    for (int n = 0; n < count; n++) begin
      mode = pick_mode();
      b    = pick_operand();
      // make zero divisors common enough to matter
      if ((mode == sbamd_pkg::MODE_DIV || mode == sbamd_pkg::MODE_REM) &&
          $urandom_range(0, 9) == 0)
        b = '0;
      send_request(mode, pick_operand(), b);
    end
  endtask

  // ---------------------------------------------------------------- tests --

  // corners of every operation, zero divisors, the wrapping quotient and
  // the undefined mode codes
  task automatic test_directed();
    send_request(sbamd_pkg::MODE_ADD, 127, 1);
    send_request(sbamd_pkg::MODE_ADD, -128, -1);
    send_request(sbamd_pkg::MODE_ADD, -1, 1);
    send_request(sbamd_pkg::MODE_SUB, -128, 1);
    send_request(sbamd_pkg::MODE_SUB, 127, -1);
    send_request(sbamd_pkg::MODE_SUB, 0, -128);
    send_request(sbamd_pkg::MODE_MUL, -128, -1);
    send_request(sbamd_pkg::MODE_MUL, 127, 127);
    send_request(sbamd_pkg::MODE_MUL, -1, -1);
    send_request(sbamd_pkg::MODE_DIV, 7, 2);
    send_request(sbamd_pkg::MODE_DIV, -7, 2);
    send_request(sbamd_pkg::MODE_DIV, 7, -2);
    send_request(sbamd_pkg::MODE_DIV, -128, -1);
    send_request(sbamd_pkg::MODE_DIV, 100, -128);
    send_request(sbamd_pkg::MODE_DIV, -128, -128);
    send_request(sbamd_pkg::MODE_DIV, 5, 0);
    send_request(sbamd_pkg::MODE_DIV, -5, 0);
    send_request(sbamd_pkg::MODE_REM, -7, 2);
    send_request(sbamd_pkg::MODE_REM, 7, -2);
    send_request(sbamd_pkg::MODE_REM, -128, -1);
    send_request(sbamd_pkg::MODE_REM, -100, 0);
    send_request(sbamd_pkg::MODE_REM, 127, -128);
    send_request(MODE_UNUSED_FIRST, -1, -1);
    send_request(MODE_CODE_LAST, 127, -128);
    wait_drained();
  endtask

  // random mix with idling on both sides, pausing for a full drain now and then
  task automatic test_random_mix();
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    for (int blk = 0; blk < 5; blk++) begin
      send_random(230);
      wait_drained();
    end
  endtask

  // no idling anywhere, one request per cycle through the whole pipe
  task automatic test_back_to_back();
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    send_random(200);
    wait_drained();
    receiver_gaps_on = 1'b1;
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the pipe fills and in_ready must drop
  task automatic test_output_hold();
    sender_gaps_on = 1'b0;
    hold_pending   = 1'b1;
    send_random(60);
    wait_drained();
    sender_gaps_on = 1'b1;
  endtask

  // ------------------------------------------------------------- receiver --
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = receiver_gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // ---------------------------------------------- prediction and checking --
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(predict_alu(in_mode, in_operand_a, in_operand_b));
        request_count++;
        mode_count[in_mode]++;
      end
      if (in_valid && !in_ready)
        backpressure_cycles++;
      if (out_valid && out_ready) begin
        result_count++;
        if (pending_results.size() == 0)
          report_mismatch($sformatf("result %0d with no request outstanding", out_result));
        else begin
          oldest = pending_results.pop_front();
          if (oldest.div_by_zero)
            dz_count++;
          if (out_result !== oldest.result)
            report_mismatch($sformatf("result %0d: got %0d, expected %0d",
                                      result_count, out_result, oldest.result));
          if (out_div_by_zero !== oldest.div_by_zero)
            report_mismatch($sformatf("result %0d: div_by_zero got %b, expected %b",
                                      result_count, out_div_by_zero, oldest.div_by_zero));
        end
      end
    end
  end

  // watchdog: too long with neither channel moving means the unit has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAIL signed_byte_alu_mul_div");
      $finish;
    end
  end

  // ----------------------------------------------------------------- main --
  initial begin
    int unused_total;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = sbamd_pkg::MODE_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix();
    test_back_to_back();
    test_output_hold();

    wait_drained();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    unused_total = 0;
    for (int m = MODE_UNUSED_FIRST; m <= MODE_CODE_LAST; m++)
      unused_total += mode_count[m];

    $display("covered %0d requests: add %0d, sub %0d, mul %0d, div %0d, rem %0d, unused %0d",
             request_count, mode_count[sbamd_pkg::MODE_ADD], mode_count[sbamd_pkg::MODE_SUB],
             mode_count[sbamd_pkg::MODE_MUL], mode_count[sbamd_pkg::MODE_DIV],
             mode_count[sbamd_pkg::MODE_REM], unused_total);
    $display("%0d results checked, %0d with a zero divisor, %0d cycles of input backpressure",
             result_count, dz_count, backpressure_cycles);
    if (error_count == 0)
      $display("PASS signed_byte_alu_mul_div");
    else
      $display("FAIL signed_byte_alu_mul_div");
    $finish;
  end

endmodule
